// ===== rtl/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg: shared types, codes and microcode for the LCD nibble sequencer
// Holds the register map, command codes, control word layout and the
// read-only program that turns each command into pin phases.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

    // Number of display lines served by the cursor command (1 to 4)
    localparam int DISPLAY_LINES = 2;

    // Command codes
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_CURSOR = 2'd1;
    localparam logic [1:0] CMD_INIT   = 2'd2;

    // Register indexes on the configuration port
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_DISPLAY_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FUNCTION_SET   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_ONE       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LINE_TWO       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LINE_THREE     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LINE_FOUR      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DISPLAY_LENGTH = 3'd6;

    typedef struct packed {
        logic [7:0] display_mode;
        logic [7:0] function_set;
        logic [6:0] line_one_start;
        logic [6:0] line_two_start;
        logic [6:0] line_three_start;
        logic [6:0] line_four_start;
        logic [5:0] display_length;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        display_mode:     8'd12,
        function_set:     8'd40,
        line_one_start:   7'd0,
        line_two_start:   7'd64,
        line_three_start: 7'd20,
        line_four_start:  7'd84,
        display_length:   6'd16
    };

    // Cursor unit result
    typedef struct packed {
        logic       valid;
        logic [7:0] addr;
    } cursor_t;

    localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;

    // Control word
    typedef enum logic [2:0] {
        BSRC_DATA,
        BSRC_CURSOR,
        BSRC_FSET,
        BSRC_DMODE,
        BSRC_LIT
    } bsrc_t;

    typedef enum logic {
        HALF_HI,
        HALF_LO
    } half_t;

    typedef struct packed {
        logic       en;
        bsrc_t      bsrc;
        half_t      half;
        logic [7:0] lit;
        logic [6:0] wait_ms;
        logic       last;
    } ucode_t;

    // Program layout
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEP_WRITE  = 6'd0;
    localparam logic [STEP_W-1:0] STEP_CURSOR = 6'd4;
    localparam logic [STEP_W-1:0] STEP_INIT   = 6'd8;
    localparam logic [STEP_W-1:0] STEP_END    = 6'd32;

    localparam logic [7:0] INSTR_DISPLAY_OFF = 8'h08;
    localparam logic [7:0] INSTR_CLEAR       = 8'h01;

    function automatic ucode_t uc(input logic en, input bsrc_t bsrc, input half_t half,
                                  input logic [7:0] lit, input logic [6:0] wait_ms,
                                  input logic last);
        ucode_t w;
        w.en      = en;
        w.bsrc    = bsrc;
        w.half    = half;
        w.lit     = lit;
        w.wait_ms = wait_ms;
        w.last    = last;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            // write byte
            6'd0:  w = uc(1'b1, BSRC_DATA,   HALF_HI, 8'h00, 7'd1,   1'b0);
            6'd1:  w = uc(1'b0, BSRC_DATA,   HALF_HI, 8'h00, 7'd1,   1'b0);
            6'd2:  w = uc(1'b1, BSRC_DATA,   HALF_LO, 8'h00, 7'd1,   1'b0);
            6'd3:  w = uc(1'b0, BSRC_DATA,   HALF_LO, 8'h00, 7'd2,   1'b1);
            // set cursor
            6'd4:  w = uc(1'b1, BSRC_CURSOR, HALF_HI, 8'h00, 7'd1,   1'b0);
            6'd5:  w = uc(1'b0, BSRC_CURSOR, HALF_HI, 8'h00, 7'd1,   1'b0);
            6'd6:  w = uc(1'b1, BSRC_CURSOR, HALF_LO, 8'h00, 7'd1,   1'b0);
            6'd7:  w = uc(1'b0, BSRC_CURSOR, HALF_LO, 8'h00, 7'd2,   1'b1);
            // power-up: idle, three 8-bit wakeups, switch to 4-bit
            6'd8:  w = uc(1'b0, BSRC_LIT,    HALF_LO, 8'h00, 7'd100, 1'b0);
            6'd9:  w = uc(1'b1, BSRC_LIT,    HALF_LO, 8'h03, 7'd1,   1'b0);
            6'd10: w = uc(1'b0, BSRC_LIT,    HALF_LO, 8'h03, 7'd6,   1'b0);
            6'd11: w = uc(1'b1, BSRC_LIT,    HALF_LO, 8'h03, 7'd1,   1'b0);
            6'd12: w = uc(1'b0, BSRC_LIT,    HALF_LO, 8'h03, 7'd2,   1'b0);
            6'd13: w = uc(1'b1, BSRC_LIT,    HALF_LO, 8'h03, 7'd1,   1'b0);
            6'd14: w = uc(1'b0, BSRC_LIT,    HALF_LO, 8'h03, 7'd2,   1'b0);
            6'd15: w = uc(1'b1, BSRC_LIT,    HALF_LO, 8'h02, 7'd1,   1'b0);
            6'd16: w = uc(1'b0, BSRC_LIT,    HALF_LO, 8'h02, 7'd6,   1'b0);
            // function set, with a 5 ms longer settle
            6'd17: w = uc(1'b1, BSRC_FSET,   HALF_HI, 8'h00, 7'd1,   1'b0);
            6'd18: w = uc(1'b0, BSRC_FSET,   HALF_HI, 8'h00, 7'd1,   1'b0);
            6'd19: w = uc(1'b1, BSRC_FSET,   HALF_LO, 8'h00, 7'd1,   1'b0);
            6'd20: w = uc(1'b0, BSRC_FSET,   HALF_LO, 8'h00, 7'd7,   1'b0);
            // display off
            6'd21: w = uc(1'b1, BSRC_LIT, HALF_HI, INSTR_DISPLAY_OFF, 7'd1, 1'b0);
            6'd22: w = uc(1'b0, BSRC_LIT, HALF_HI, INSTR_DISPLAY_OFF, 7'd1, 1'b0);
            6'd23: w = uc(1'b1, BSRC_LIT, HALF_LO, INSTR_DISPLAY_OFF, 7'd1, 1'b0);
            6'd24: w = uc(1'b0, BSRC_LIT, HALF_LO, INSTR_DISPLAY_OFF, 7'd2, 1'b0);
            // clear
            6'd25: w = uc(1'b1, BSRC_LIT, HALF_HI, INSTR_CLEAR, 7'd1, 1'b0);
            6'd26: w = uc(1'b0, BSRC_LIT, HALF_HI, INSTR_CLEAR, 7'd1, 1'b0);
            6'd27: w = uc(1'b1, BSRC_LIT, HALF_LO, INSTR_CLEAR, 7'd1, 1'b0);
            6'd28: w = uc(1'b0, BSRC_LIT, HALF_LO, INSTR_CLEAR, 7'd2, 1'b0);
            // display mode
            6'd29: w = uc(1'b1, BSRC_DMODE,  HALF_HI, 8'h00, 7'd1,   1'b0);
            6'd30: w = uc(1'b0, BSRC_DMODE,  HALF_HI, 8'h00, 7'd1,   1'b0);
            6'd31: w = uc(1'b1, BSRC_DMODE,  HALF_LO, 8'h00, 7'd1,   1'b0);
            6'd32: w = uc(1'b0, BSRC_DMODE,  HALF_LO, 8'h00, 7'd2,   1'b1);
            default: w = uc(1'b0, BSRC_LIT,  HALF_LO, 8'h00, 7'd1,   1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer: 4-bit character LCD command sequencer
// Turns write, cursor and init requests into timed pin phases (E, RS,
// D7..D4, hold time) driven by a microcoded step counter.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                  contents
//  -------   ---  -------------------------  -------------------------------
//  s_axis    in   s_axis_tvalid/tready       one request: cmd, byte, line...
//  m_axis    out  m_axis_tvalid/tready       one pin phase per beat, tlast
//                                            on the final phase of a request
//  cfg       in   cfg_valid/cfg_ready        register index + write data
//
//  Flow: a request is accepted and dispatched, then the step counter issues
//  one phase per cycle, unless stalled, through the routine for its command.
//  A cursor request to a line off the display and an unknown command are
//  accepted but emit nothing.
//  Reset: rst_n clears the sequencer and the output valid flag and restores
//  the register defaults; no clearing pass.
//  Stalls: the step counter holds while the output register is full and
//  m_axis_tready is low. A new request is taken as soon as the last phase
//  of the previous one sits in the output register.
//
`default_nettype none

module char_lcd_nibble_sequencer #(
    parameter int LINES = lcdseq_pkg::DISPLAY_LINES
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [15:8] line_number,
                                        // [23:16] column
    input  logic [2:0]  s_axis_tuser,   // [1:0] cmd, [2] reg_select

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] pin_enable, [4:1] pin_data,
                                        // [11:5] wait_ms, [15:12] zero
    output logic        m_axis_tuser,   // [0] pin_rs
    output logic        m_axis_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import lcdseq_pkg::*;

    // request fields
    logic [1:0] in_cmd;
    logic [7:0] in_data_byte;
    logic       in_reg_select;
    logic [7:0] in_line_number;
    logic [7:0] in_column;

    assign in_cmd         = s_axis_tuser[1:0];
    assign in_reg_select  = s_axis_tuser[2];
    assign in_data_byte   = s_axis_tdata[7:0];
    assign in_line_number = s_axis_tdata[15:8];
    assign in_column      = s_axis_tdata[23:16];

    // configuration registers
    cfg_t cfg_reg;

    // sequencer state
    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;

    // operands latched on accept
    logic [7:0] byte_reg;
    logic       rs_reg;
    logic [7:0] cursor_reg;

    // output register
    logic       out_valid_reg;
    logic       out_en_reg;
    logic       out_rs_reg;
    logic [3:0] out_nib_reg;
    logic [6:0] out_wait_reg;
    logic       out_last_reg;

    cursor_t cursor;
    ucode_t  uw;
    logic    s_accept;
    logic    out_free;
    logic    issue;
    logic [7:0] sel_byte;
    logic [3:0] sel_nib;
    logic       sel_rs;

    lcdseq_cursor #(
        .LINES (LINES)
    ) u_cursor (
        .cfg         (cfg_reg),
        .line_number (in_line_number),
        .column      (in_column),
        .cursor      (cursor)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // room in the output register for the next phase
    assign out_free = !out_valid_reg || m_axis_tready;
    assign issue    = busy_reg && out_free;

    // fetch the control word of the current step
    assign uw = ucode_rom(step_reg);

    always_comb
    begin
        case (uw.bsrc)
            BSRC_DATA:   sel_byte = byte_reg;
            BSRC_CURSOR: sel_byte = cursor_reg;
            BSRC_FSET:   sel_byte = cfg_reg.function_set;
            BSRC_DMODE:  sel_byte = cfg_reg.display_mode;
            BSRC_LIT:    sel_byte = uw.lit;
            default:     sel_byte = uw.lit;
        endcase
        sel_nib = (uw.half == HALF_HI) ? sel_byte[7:4] : sel_byte[3:0];
        // only a plain byte write drives RS from the request
        sel_rs  = (uw.bsrc == BSRC_DATA) ? rs_reg : 1'b0;
    end

    // control: config, dispatch, step counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            busy_reg      <= 1'b0;
            step_reg      <= STEP_WRITE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DISPLAY_MODE:   cfg_reg.display_mode     <= cfg_data;
                    REG_FUNCTION_SET:   cfg_reg.function_set     <= cfg_data;
                    REG_LINE_ONE:       cfg_reg.line_one_start   <= cfg_data[6:0];
                    REG_LINE_TWO:       cfg_reg.line_two_start   <= cfg_data[6:0];
                    REG_LINE_THREE:     cfg_reg.line_three_start <= cfg_data[6:0];
                    REG_LINE_FOUR:      cfg_reg.line_four_start  <= cfg_data[6:0];
                    REG_DISPLAY_LENGTH: cfg_reg.display_length   <= cfg_data[5:0];
                    default:            ;
                endcase
            end

            // load a new phase, or drop the current one once taken
            if (issue)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (s_accept)
            begin
                // jump to the routine for this command
                case (in_cmd)
                    CMD_WRITE:
                    begin
                        busy_reg <= 1'b1;
                        step_reg <= STEP_WRITE;
                    end
                    CMD_CURSOR:
                    begin
                        busy_reg <= cursor.valid;
                        step_reg <= STEP_CURSOR;
                    end
                    CMD_INIT:
                    begin
                        busy_reg <= 1'b1;
                        step_reg <= STEP_INIT;
                    end
                    default: ;
                endcase
            end
            else if (issue)
            begin
                if (uw.last)
                    busy_reg <= 1'b0;
                else
                    step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            byte_reg   <= in_data_byte;
            rs_reg     <= in_reg_select;
            cursor_reg <= cursor.addr;
        end
        if (issue)
        begin
            out_en_reg   <= uw.en;
            out_rs_reg   <= sel_rs;
            out_nib_reg  <= sel_nib;
            out_wait_reg <= uw.wait_ms;
            out_last_reg <= uw.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_wait_reg, out_nib_reg, out_en_reg};
    assign m_axis_tuser  = out_rs_reg;
    assign m_axis_tlast  = out_last_reg;

    // the step counter stays inside the program while running
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= STEP_END))
        else $error("step counter ran past the program");

    // issuing the final control word ends the routine
    assert property (@(posedge clk) disable iff (!rst_n)
        (issue && uw.last) |=> (!busy_reg && out_valid_reg && m_axis_tlast))
        else $error("routine did not end on its last phase");

    // an init request lands on the start of the init routine
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && in_cmd == CMD_INIT) |=> (busy_reg && step_reg == STEP_INIT))
        else $error("init dispatch went astray");

    // every emitted phase holds for at least one millisecond
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_wait_reg != 7'd0))
        else $error("phase with zero hold time");

endmodule

`default_nettype wire

// ===== rtl/lcdseq_cursor.sv =====
// ----------------------------------------------------------------------------
// lcdseq_cursor: cursor address unit
// Clamps the column to the line length, picks the line start and forms the
// set-address instruction; flags lines outside the display.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_cursor #(
    parameter int LINES = lcdseq_pkg::DISPLAY_LINES
) (
    input  lcdseq_pkg::cfg_t    cfg,
    input  logic [7:0]          line_number,
    input  logic [7:0]          column,
    output lcdseq_pkg::cursor_t cursor
);
    import lcdseq_pkg::*;

    logic [5:0] len;
    logic [7:0] col_clamped;
    logic [6:0] start;
    logic [1:0] line_idx;

    always_comb
    begin
        // zero length behaves as one
        len         = (cfg.display_length == 6'd0) ? 6'd1 : cfg.display_length;
        col_clamped = (column >= {2'b00, len}) ? {2'b00, len - 6'd1} : column;
        line_idx    = 2'(line_number - 8'd1);
        case (line_idx)
            2'd0:    start = cfg.line_one_start;
            2'd1:    start = cfg.line_two_start;
            2'd2:    start = cfg.line_three_start;
            2'd3:    start = cfg.line_four_start;
            default: start = cfg.line_one_start;
        endcase
        cursor.valid = (line_number != 8'd0) && (line_number <= 8'(LINES));
        cursor.addr  = SET_DDRAM_ADDR + {1'b0, start} + col_clamped;
    end

endmodule

`default_nettype wire
